@@ sv/pgt_pkg.sv @@
// Shared constants for the polar Gaussian transform core.
package pgt_pkg;

  // Default sample width of the uniform inputs.
  localparam int UNIFORM_BITS_DEF = 16;

  // Result and configuration data width.
  localparam int DATA_W = 32;
  localparam int STD_W  = 31;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STD_DEV = 1'b1;

  // Register reset values.
  localparam logic [DATA_W-1:0] MEAN_RESET    = '0;
  localparam logic [STD_W-1:0]  STD_DEV_RESET = 31'd65536;

  // Logarithm: Q1.31 mantissa, 24 fraction bits by square-and-compare.
  localparam int MANT_W   = 32;
  localparam int LOG_FRAC = 24;

  // 2 ln 2 in Q1.31 and the rounding of the scaled logarithm.
  localparam logic [MANT_W-1:0] TWO_LN2_Q31 = 32'd2977044472;
  localparam int K_SH = 31;

  // Ratio u^2 / r in Q1.30: 31 quotient bits over a 33-bit divisor.
  localparam int Q_W       = 31;
  localparam int DV_W      = 33;
  localparam int DIV_STEPS = Q_W;

  // Square root input width.
  localparam int SQRT_IN_W = 64;

  // Rounding of std_dev * |z| from Q.43 to Q.16.
  localparam int RND_SH = 27;

  // Saturation bounds.
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage

@@ sv/pgt_if.sv @@
// Valid/ready channel interfaces for uniform pairs and normal variates.
interface pgt_in_if #(
  parameter int W = pgt_pkg::UNIFORM_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] uniform_a;
  logic signed [W-1:0] uniform_b;

  modport source (output valid, output uniform_a, output uniform_b, input ready);
  modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface pgt_out_if ();
  logic                             valid;
  logic                             ready;
  logic signed [pgt_pkg::DATA_W-1:0] variate;
  logic                             last;

  modport source (output valid, output variate, output last, input ready);
  modport sink   (input valid, input variate, input last, output ready);
endinterface

@@ sv/pgt_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage.
module pgt_sqrt_pipe #(
  parameter int IN_W = pgt_pkg::SQRT_IN_W
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [IN_W-1:0]   x_in,
  output logic [IN_W/2-1:0] root
);
  localparam int N = IN_W / 2;

  logic [IN_W-1:0] x_r   [0:N-1];
  logic [IN_W-1:0] res_r [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * k);
    logic [IN_W-1:0] x_i;
    logic [IN_W-1:0] res_i;
    logic [IN_W-1:0] trial;
    logic [IN_W-1:0] x_nxt;
    logic [IN_W-1:0] res_nxt;

    if (k == 0) begin : g_first
      assign x_i   = x_in;
      assign res_i = '0;
    end else begin : g_next
      assign x_i   = x_r[k-1];
      assign res_i = res_r[k-1];
    end

    // Try the next root bit, keep it when the remainder allows
    always_comb begin
      trial = res_i + BIT;
      if (x_i >= trial) begin
        x_nxt   = x_i - trial;
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        x_nxt   = x_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k]   <= x_nxt;
        res_r[k] <= res_nxt;
      end
    end
  end

  assign root = res_r[N-1][N-1:0];

endmodule

@@ sv/polar_gaussian_transform_core.sv @@
// A pair that passes rejection shows its first variate on the result port, then its second.
// One pair enters per cycle while the pipeline advances; a pair that passes rejection holds the
// single output register until both variates are taken, and the whole pipeline stalls meanwhile.
// Depth comes from the 31-step divider (log squarings ride along) and the 32-step square root.
// Reset (synchronous, rst_n low) empties the pipeline, sets mean to 0 and std_dev to 1.0.
module polar_gaussian_transform_core #(
  parameter int UNIFORM_BITS = pgt_pkg::UNIFORM_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pgt_in_if.sink                           in_ch,
  pgt_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pgt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pgt_pkg::DATA_W-1:0]       cfg_data
);
  import pgt_pkg::*;

  localparam int UB      = UNIFORM_BITS;
  localparam int RW      = 2 * UB;
  localparam int P_W     = $clog2(RW);
  localparam int NL2_W   = $clog2(RW - 1) + LOG_FRAC;
  localparam int L_W     = NL2_W + 1;
  localparam int LK_W    = NL2_W + MANT_W;
  localparam int LQ_W    = L_W + Q_W;
  localparam int ROOT_W  = SQRT_IN_W / 2;
  localparam int SP_W    = STD_W + ROOT_W;
  localparam int MAG_W   = SP_W + 1 - RND_SH;
  localparam int SUM_W   = MAG_W + 2;

  // Configuration registers
  logic signed [DATA_W-1:0] mean_r;
  logic [STD_W-1:0]         std_dev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r    <= MEAN_RESET;
      std_dev_r <= STD_DEV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEAN:    mean_r    <= cfg_data;
        CFG_STD_DEV: std_dev_r <= cfg_data[STD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: the output register is empty or hands over its second variate
  logic fin_v_r;
  logic fin_sel_r;
  logic adv;

  assign adv         = !fin_v_r || (out_ch.ready && fin_sel_r);
  assign in_ch.ready = adv;

  // Stage A: capture the uniform pair
  logic                 a_v_r;
  logic signed [UB-1:0] a_r;
  logic signed [UB-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= in_ch.uniform_a;
      b_r <= in_ch.uniform_b;
    end
  end

  // Stage B: squares, radius and rejection
  logic [UB-1:0] ma;
  logic [UB-1:0] mb;
  logic [RW-1:0] sa_nxt;
  logic [RW-1:0] sb_nxt;
  logic [RW-1:0] r_nxt;
  logic          ok_nxt;

  always_comb begin
    ma     = a_r[UB-1] ? (~a_r + 1'b1) : a_r;
    mb     = b_r[UB-1] ? (~b_r + 1'b1) : b_r;
    sa_nxt = RW'(ma) * RW'(ma);
    sb_nxt = RW'(mb) * RW'(mb);
    r_nxt  = sa_nxt + sb_nxt;
    ok_nxt = (r_nxt != '0) && (r_nxt <= (RW'(1) << (RW - 2)));
  end

  logic          b_v_r;
  logic [RW-1:0] sa_r;
  logic [RW-1:0] sb_r;
  logic [RW-1:0] r_r;
  logic          b_na_r;
  logic          b_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r && ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r   <= sa_nxt;
      sb_r   <= sb_nxt;
      r_r    <= r_nxt;
      b_na_r <= a_r[UB-1];
      b_nb_r <= b_r[UB-1];
    end
  end

  // Stage C: normalize the radius, align the divider operands
  logic [P_W-1:0]       p_nxt;
  logic [RW+MANT_W-1:0] ext;
  logic [P_W-1:0]       sh;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < RW; i++) begin
      if (r_r[i]) p_nxt = P_W'(i);
    end
    ext = {r_r, {MANT_W{1'b0}}} << (P_W'(RW - 1) - p_nxt);
    if (int'(p_nxt) > DV_W - 1) sh = P_W'(int'(p_nxt) - (DV_W - 1));
    else                        sh = '0;
  end

  // Divider and logarithm stages; index 0 is stage C
  logic                dv_v_r    [0:DIV_STEPS];
  logic [P_W-1:0]      dv_p_r    [0:DIV_STEPS];
  logic [MANT_W-1:0]   dv_m_r    [0:DIV_STEPS];
  logic [LOG_FRAC-1:0] dv_frac_r [0:DIV_STEPS];
  logic [DV_W-1:0]     dv_rr_r   [0:DIV_STEPS];
  logic [DV_W-1:0]     dv_ra_r   [0:DIV_STEPS];
  logic [DV_W-1:0]     dv_rb_r   [0:DIV_STEPS];
  logic [Q_W-1:0]      dv_qa_r   [0:DIV_STEPS];
  logic [Q_W-1:0]      dv_qb_r   [0:DIV_STEPS];
  logic                dv_na_r   [0:DIV_STEPS];
  logic                dv_nb_r   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_p_r[0]    <= p_nxt;
      dv_m_r[0]    <= ext[RW+MANT_W-1 -: MANT_W];
      dv_frac_r[0] <= '0;
      dv_rr_r[0]   <= DV_W'(r_r >> sh);
      dv_ra_r[0]   <= DV_W'(sa_r >> sh);
      dv_rb_r[0]   <= DV_W'(sb_r >> sh);
      dv_qa_r[0]   <= '0;
      dv_qb_r[0]   <= '0;
      dv_na_r[0]   <= b_na_r;
      dv_nb_r[0]   <= b_nb_r;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_dv
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sq_t;
    logic [MANT_W-1:0]   m_nxt;
    logic                f_bit;
    logic [DV_W:0]       ra_s;
    logic [DV_W:0]       rb_s;
    logic                qa_bit;
    logic                qb_bit;
    logic [DV_W-1:0]     ra_nxt;
    logic [DV_W-1:0]     rb_nxt;

    // One quotient bit for each lane, and one log squaring in the first LOG_FRAC steps
    always_comb begin
      sq     = dv_m_r[k-1] * dv_m_r[k-1];
      sq_t   = sq[2*MANT_W-1 -: MANT_W+1];
      f_bit  = sq_t[MANT_W];
      m_nxt  = f_bit ? sq_t[MANT_W:1] : sq_t[MANT_W-1:0];
      ra_s   = (k == 1) ? {1'b0, dv_ra_r[k-1]} : {dv_ra_r[k-1], 1'b0};
      rb_s   = (k == 1) ? {1'b0, dv_rb_r[k-1]} : {dv_rb_r[k-1], 1'b0};
      qa_bit = ra_s >= {1'b0, dv_rr_r[k-1]};
      qb_bit = rb_s >= {1'b0, dv_rr_r[k-1]};
      ra_nxt = qa_bit ? DV_W'(ra_s - {1'b0, dv_rr_r[k-1]}) : DV_W'(ra_s);
      rb_nxt = qb_bit ? DV_W'(rb_s - {1'b0, dv_rr_r[k-1]}) : DV_W'(rb_s);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (adv) begin
        dv_v_r[k] <= dv_v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (k <= LOG_FRAC) begin
          dv_m_r[k]    <= m_nxt;
          dv_frac_r[k] <= {dv_frac_r[k-1][LOG_FRAC-2:0], f_bit};
        end else begin
          dv_m_r[k]    <= dv_m_r[k-1];
          dv_frac_r[k] <= dv_frac_r[k-1];
        end
        dv_p_r[k]  <= dv_p_r[k-1];
        dv_rr_r[k] <= dv_rr_r[k-1];
        dv_ra_r[k] <= ra_nxt;
        dv_rb_r[k] <= rb_nxt;
        dv_qa_r[k] <= {dv_qa_r[k-1][Q_W-2:0], qa_bit};
        dv_qb_r[k] <= {dv_qb_r[k-1][Q_W-2:0], qb_bit};
        dv_na_r[k] <= dv_na_r[k-1];
        dv_nb_r[k] <= dv_nb_r[k-1];
      end
    end
  end

  // Stage D: -log2 r in Q.24
  logic [NL2_W-1:0] ip;
  logic [NL2_W-1:0] nl2_nxt;

  always_comb begin
    ip      = NL2_W'(RW - 2) - NL2_W'(dv_p_r[DIV_STEPS]);
    nl2_nxt = (ip << LOG_FRAC) - NL2_W'(dv_frac_r[DIV_STEPS]);
  end

  logic             d_v_r;
  logic [NL2_W-1:0] d_nl2_r;
  logic [Q_W-1:0]   d_qa_r;
  logic [Q_W-1:0]   d_qb_r;
  logic             d_na_r;
  logic             d_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_nl2_r <= nl2_nxt;
      d_qa_r  <= dv_qa_r[DIV_STEPS];
      d_qb_r  <= dv_qb_r[DIV_STEPS];
      d_na_r  <= dv_na_r[DIV_STEPS];
      d_nb_r  <= dv_nb_r[DIV_STEPS];
    end
  end

  // Stage E: L = -2 ln r in Q.24, rounded
  logic [LK_W-1:0] lk;
  logic [LK_W:0]   lk_rnd;

  always_comb begin
    lk     = LK_W'(d_nl2_r) * LK_W'(TWO_LN2_Q31);
    lk_rnd = {1'b0, lk} + ((LK_W + 1)'(1) << (K_SH - 1));
  end

  logic           e_v_r;
  logic [L_W-1:0] e_l_r;
  logic [Q_W-1:0] e_qa_r;
  logic [Q_W-1:0] e_qb_r;
  logic           e_na_r;
  logic           e_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_l_r  <= lk_rnd[K_SH +: L_W];
      e_qa_r <= d_qa_r;
      e_qb_r <= d_qb_r;
      e_na_r <= d_na_r;
      e_nb_r <= d_nb_r;
    end
  end

  // Stage F: radicands L * q
  logic            f_v_r;
  logic [LQ_W-1:0] f_pa_r;
  logic [LQ_W-1:0] f_pb_r;
  logic            f_na_r;
  logic            f_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_pa_r <= LQ_W'(e_l_r) * LQ_W'(e_qa_r);
      f_pb_r <= LQ_W'(e_l_r) * LQ_W'(e_qb_r);
      f_na_r <= e_na_r;
      f_nb_r <= e_nb_r;
    end
  end

  // Square root stages, with valid and signs traveling alongside
  logic [ROOT_W-1:0] za;
  logic [ROOT_W-1:0] zb;

  pgt_sqrt_pipe #(.IN_W(SQRT_IN_W)) u_sqrt_a (
    .clk  (clk),
    .adv  (adv),
    .x_in (SQRT_IN_W'(f_pa_r)),
    .root (za)
  );

  pgt_sqrt_pipe #(.IN_W(SQRT_IN_W)) u_sqrt_b (
    .clk  (clk),
    .adv  (adv),
    .x_in (SQRT_IN_W'(f_pb_r)),
    .root (zb)
  );

  logic sq_v_r  [0:ROOT_W-1];
  logic sq_na_r [0:ROOT_W-1];
  logic sq_nb_r [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ROOT_W; i++) sq_v_r[i] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= f_v_r;
      for (int i = 1; i < ROOT_W; i++) sq_v_r[i] <= sq_v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_na_r[0] <= f_na_r;
      sq_nb_r[0] <= f_nb_r;
      for (int i = 1; i < ROOT_W; i++) begin
        sq_na_r[i] <= sq_na_r[i-1];
        sq_nb_r[i] <= sq_nb_r[i-1];
      end
    end
  end

  // Stage G: scale by std_dev
  logic            g_v_r;
  logic [SP_W-1:0] g_spa_r;
  logic [SP_W-1:0] g_spb_r;
  logic            g_na_r;
  logic            g_nb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (adv) begin
      g_v_r <= sq_v_r[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_spa_r <= SP_W'(std_dev_r) * SP_W'(za);
      g_spb_r <= SP_W'(std_dev_r) * SP_W'(zb);
      g_na_r  <= sq_na_r[ROOT_W-1];
      g_nb_r  <= sq_nb_r[ROOT_W-1];
    end
  end

  // Round to Q16.16, apply sign, add mean and saturate
  function automatic logic [DATA_W-1:0] finish_variate(
    input logic [SP_W-1:0]          sp,
    input logic                     neg,
    input logic signed [DATA_W-1:0] mn
  );
    logic [SP_W:0]             rnd;
    logic [MAG_W-1:0]          mag;
    logic signed [SUM_W-1:0]   val;
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-DATA_W:0]     top;
    logic [DATA_W-1:0]         res;
    rnd = {1'b0, sp} + ((SP_W + 1)'(1) << (RND_SH - 1));
    mag = rnd[SP_W:RND_SH];
    val = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = val + SUM_W'(mn);
    top = sum[SUM_W-1:DATA_W-1];
    if (top == '0 || top == '1) res = sum[DATA_W-1:0];
    else if (sum[SUM_W-1])      res = SAT_MIN;
    else                        res = SAT_MAX;
    return res;
  endfunction

  // Output register: holds both variates of a pair, first then second
  logic [DATA_W-1:0] fin_va_r;
  logic [DATA_W-1:0] fin_vb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r   <= 1'b0;
      fin_sel_r <= 1'b0;
    end else if (adv) begin
      fin_v_r   <= g_v_r;
      fin_sel_r <= 1'b0;
    end else if (out_ch.ready) begin
      fin_sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_va_r <= finish_variate(g_spa_r, g_na_r, mean_r);
      fin_vb_r <= finish_variate(g_spb_r, g_nb_r, mean_r);
    end
  end

  assign out_ch.valid   = fin_v_r;
  assign out_ch.variate = fin_sel_r ? fin_vb_r : fin_va_r;
  assign out_ch.last    = fin_sel_r;

endmodule

@@ sv/pgt_checker.sv @@
// Port-level assertions for the polar Gaussian transform core, with its bind.
module pgt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_last,
  input logic [pgt_pkg::DATA_W-1:0]   out_variate
);

  // Reset empties the result port
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last) && $stable(out_variate))
    else $error("stalled result changed");

  // The second variate follows the first at once
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_last)
    else $error("second variate missing after first");

  // An empty result port never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result port");

endmodule

bind polar_gaussian_transform_core pgt_checker u_pgt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_last    (out_ch.last),
  .out_variate (out_ch.variate)
);
